// ===== design/lzss_pkg.sv =====
// Shared types and constants of the LZSS stream decoder.
// Depends on nothing; the front, queue, back and top level import it.
`default_nettype none

package lzss_pkg;

  // Field widths fixed by the stream format
  localparam int BYTE_W  = 8;
  localparam int DIST_W  = 12;
  localparam int COUNT_W = 16;
  localparam int LEN_W   = 5;   // holds 15 plus the largest length bias

  localparam logic [DIST_W-1:0] DIST_MASK = 12'h0FFF;
  localparam logic [3:0]        LEN_MASK  = 4'h0F;

  // End status codes
  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_LIMIT   = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_EOF     = 2'd3;

  // Command opcodes passed from parser to executor
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_LIT  = 2'd1;
  localparam logic [1:0] OP_COPY = 2'd2;

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [1:0]         op;
    logic [BYTE_W-1:0]  lit;
    logic [DIST_W-1:0]  copy_dist;
    logic [LEN_W-1:0]   len;         // bytes to copy, already cut at the limit
    logic               has_status;  // a status item follows the bytes
    logic [1:0]         end_status;
    logic [COUNT_W-1:0] count;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/lzss_if.sv =====
// Valid/ready channel interfaces of the LZSS stream decoder.
// Depend on nothing; used by the front, back and top level.
`default_nettype none

interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       chunk_end;

  modport source (output valid, output code_byte, output chunk_end, input ready);
  modport sink   (input valid, input code_byte, input chunk_end, output ready);
endinterface

interface lzss_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_status;
  logic [1:0]  end_status;
  logic [15:0] produced_count;
  logic        run_last;

  modport source (output valid, output out_byte, output is_status, output end_status,
                  output produced_count, output run_last, input ready);
  modport sink   (input valid, input out_byte, input is_status, input end_status,
                  input produced_count, input run_last, output ready);
endinterface

`default_nettype wire

// ===== design/lzss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/lzss_front.sv =====
// Parser: accepts code bytes, tracks flags and output count, emits commands.
// Depends on lzss_pkg and lzss_in_if.
`default_nettype none

module lzss_front #(
  parameter int WINDOW_DEPTH = 4096,
  parameter int LENGTH_BIAS  = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [15:0]           output_limit,
  lzss_in_if.sink                    code,
  input  wire logic                  q_full,
  output logic                       q_push,
  output lzss_pkg::cmd_t             q_cmd
);
  import lzss_pkg::*;

  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  localparam logic [COUNT_W:0] DEPTH_L = (COUNT_W+1)'(WINDOW_DEPTH);
  localparam logic [LEN_W-1:0] BIAS_L  = LEN_W'(LENGTH_BIAS);

  logic [7:0]         flag_bits, flag_bits_next;
  logic [3:0]         flags_left, flags_left_next;
  logic [1:0]         phase, phase_next;
  logic [7:0]         low_byte, low_byte_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [1:0]         stop, stop_next;

  logic                 accept;
  logic [15:0]          word;
  logic [DIST_W-1:0]    copy_dist;
  logic [LEN_W-1:0]     len;
  logic [COUNT_W-1:0]   room;
  logic [LEN_W-1:0]     take;
  logic [1:0]           op;
  logic [COUNT_W-1:0]   cnt_work;
  logic [1:0]           stop_work;

  assign code.ready = !q_full;
  assign accept     = code.valid && code.ready;

  assign word      = {code.code_byte, low_byte};
  assign copy_dist = word[DIST_W-1:0] & DIST_MASK;
  assign len       = LEN_W'(word[15:12] & LEN_MASK) + BIAS_L;
  assign room      = output_limit - count;
  assign take      = ({{(COUNT_W-LEN_W){1'b0}}, len} < room) ? len : room[LEN_W-1:0];

  always_comb begin
    flag_bits_next  = flag_bits;
    flags_left_next = flags_left;
    phase_next      = phase;
    low_byte_next   = low_byte;
    cnt_work        = count;
    stop_work       = stop;
    op              = OP_NONE;

    if (stop_work == ST_RUNNING && count >= output_limit) begin
      stop_work = ST_LIMIT;
    end

    if (stop_work == ST_RUNNING) begin
      case (phase)
        PH_LOW: begin
          if (flag_bits[0]) begin
            op              = OP_LIT;
            cnt_work        = count + 16'd1;
            flag_bits_next  = flag_bits >> 1;
            flags_left_next = (flags_left != 4'd0) ? flags_left - 4'd1 : flags_left;
            phase_next      = (flags_left_next != 4'd0) ? PH_LOW : PH_FLAG;
          end else begin
            low_byte_next = code.code_byte;
            phase_next    = PH_HIGH;
          end
        end
        PH_HIGH: begin
          if (copy_dist == '0 || {{(COUNT_W-DIST_W){1'b0}}, copy_dist} > count ||
              {{(COUNT_W+1-DIST_W){1'b0}}, copy_dist} > DEPTH_L) begin
            stop_work = ST_BAD;
          end else begin
            op              = OP_COPY;
            cnt_work        = count + {{(COUNT_W-LEN_W){1'b0}}, take};
            flag_bits_next  = flag_bits >> 1;
            flags_left_next = (flags_left != 4'd0) ? flags_left - 4'd1 : flags_left;
            phase_next      = (flags_left_next != 4'd0) ? PH_LOW : PH_FLAG;
          end
        end
        default: begin
          flag_bits_next  = code.code_byte;
          flags_left_next = 4'd8;
          phase_next      = PH_LOW;
        end
      endcase
      if (stop_work == ST_RUNNING && cnt_work >= output_limit) begin
        stop_work = ST_LIMIT;
      end
    end

    count_next = cnt_work;
    stop_next  = stop_work;

    // Chunk end: report, then start the next chunk clean
    if (code.chunk_end) begin
      flag_bits_next  = '0;
      flags_left_next = '0;
      phase_next      = PH_FLAG;
      low_byte_next   = '0;
      count_next      = '0;
      stop_next       = ST_RUNNING;
    end
  end

  always_comb begin
    q_cmd.op         = op;
    q_cmd.lit        = code.code_byte;
    q_cmd.copy_dist  = copy_dist;
    q_cmd.len        = take;
    q_cmd.has_status = code.chunk_end;
    q_cmd.end_status = (stop_work != ST_RUNNING) ? stop_work : ST_EOF;
    q_cmd.count      = cnt_work;
  end

  assign q_push = accept && (op != OP_NONE || code.chunk_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_bits  <= '0;
      flags_left <= '0;
      phase      <= PH_FLAG;
      low_byte   <= '0;
      count      <= '0;
      stop       <= ST_RUNNING;
    end else if (accept) begin
      flag_bits  <= flag_bits_next;
      flags_left <= flags_left_next;
      phase      <= phase_next;
      low_byte   <= low_byte_next;
      count      <= count_next;
      stop       <= stop_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/lzss_cmd_fifo.sv =====
// Short command queue between parser and executor.
// Depends on lzss_pkg.
`default_nettype none

module lzss_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  lzss_pkg::cmd_t      push_cmd,
  input  wire logic           pop,
  output lzss_pkg::cmd_t      head,
  output logic                full,
  output logic                empty
);
  import lzss_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;

  assign full  = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command queue underflow");
  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (cnt == $past(cnt) + 1'b1))
    else $error("command queue fill count lost a push");
`endif

endmodule

`default_nettype wire

// ===== design/lzss_back.sv =====
// Executor: carries out literal, copy and status commands into the output register.
// Depends on lzss_pkg, lzss_out_if and lzss_ram.
`default_nettype none

module lzss_back #(
  parameter int WINDOW_DEPTH = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  lzss_pkg::cmd_t q_head,
  input  wire logic      q_empty,
  output logic           q_pop,
  lzss_out_if.source     result
);
  import lzss_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LIT  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_STAT = 3'd4;

  logic [2:0]       state, state_next;
  cmd_t             cur;
  logic [LEN_W-1:0] left;
  logic [AW-1:0]    wptr;

  logic             out_free;
  logic             load_byte;
  logic             load_stat;
  logic [7:0]       byte_val;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  assign out_free = !result.valid || result.ready;
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign ram_re   = (state == S_RD);
  assign ram_raddr = wptr - AW'(cur.copy_dist);

  assign load_byte = out_free && (state == S_LIT || state == S_WR);
  assign load_stat = out_free && (state == S_STAT);
  assign byte_val  = (state == S_LIT) ? cur.lit : ram_rdata;

  lzss_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_window (
    .clk   (clk),
    .we    (load_byte),
    .waddr (wptr),
    .wdata (byte_val),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          if (q_head.op == OP_LIT) begin
            state_next = S_LIT;
          end else if (q_head.op == OP_COPY) begin
            state_next = S_RD;
          end else begin
            state_next = S_STAT;
          end
        end
      end
      S_LIT: begin
        if (out_free) begin
          state_next = cur.has_status ? S_STAT : S_IDLE;
        end
      end
      S_RD: begin
        state_next = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          if (left == LEN_W'(1)) begin
            state_next = cur.has_status ? S_STAT : S_IDLE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_STAT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (q_pop) begin
      left <= q_head.len;
    end else if (state == S_WR && out_free) begin
      left <= left - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      wptr         <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_byte) begin
        wptr <= wptr + 1'b1;
      end else if (load_stat) begin
        wptr <= '0;
      end
      if (load_byte || load_stat) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      result.out_byte       <= byte_val;
      result.is_status      <= 1'b0;
      result.end_status     <= ST_RUNNING;
      result.produced_count <= '0;
      result.run_last       <= !cur.has_status &&
                               (state == S_LIT || left == LEN_W'(1));
    end else if (load_stat) begin
      result.out_byte       <= '0;
      result.is_status      <= 1'b1;
      result.end_status     <= cur.end_status;
      result.produced_count <= cur.count;
      result.run_last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/lzss12_stream_decoder.sv =====
// Top level of the LZSS stream decoder (12-bit distance, 4-bit length).
// Depends on lzss_pkg, lzss_if, lzss_front, lzss_cmd_fifo and lzss_back.
//
//   channel      | dir | handshake     | payload
//   -------------+-----+---------------+-------------------------------------------
//   code         | in  | valid/ready   | code_byte[7:0], chunk_end
//   result       | out | valid/ready   | out_byte, is_status, end_status,
//                |     |               | produced_count, run_last
//   cfg_wr_*     | in  | write enable  | cfg_wr_data[15:0] -> output_limit
//
// Flow: the parser takes one code byte per cycle while the command queue has
// room. The executor pops a command in its idle state, then emits each literal
// byte, each copied byte (window RAM read, then write and emit), and each
// status item. A copy runs the read-then-write window loop byte by byte, since
// a copy at distance one reads the byte written just before; with the default
// length bias a full back-reference copies 17 bytes.
// Reset: rst clears parser state, queue, executor state and output_limit; the
// window RAM is not cleared, and each chunk only reads back what it wrote.
// Stalls: the result register holds while result.ready is low; the queue lets
// the parser keep accepting code bytes until two commands are pending.
`default_nettype none

module lzss12_stream_decoder #(
  parameter int WINDOW_DEPTH = 4096,
  parameter int LENGTH_BIAS  = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  lzss_in_if.sink          code,
  lzss_out_if.source       result
);
  import lzss_pkg::*;

  // Expected decoded size of the chunk; the user must write it only while idle, the block does not enforce this
  logic [COUNT_W-1:0] output_limit;

  // Parser to queue
  logic q_push;
  cmd_t q_cmd;
  logic q_full;

  // Queue to executor
  cmd_t q_head;
  logic q_empty;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= '0;
    end else if (cfg_wr_en) begin
      output_limit <= cfg_wr_data;
    end
  end

  // Front: classify code bytes, decide copy lengths and stop conditions
  lzss_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .LENGTH_BIAS  (LENGTH_BIAS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .output_limit (output_limit),
    .code         (code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // Decouple parser from executor so each stalls on its own
  lzss_cmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: produce decoded bytes through the history window, then status
  lzss_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for lzss12_stream_decoder: drives compressed bytes, predicts
// every decoded byte and chunk status, and checks each result transaction in order.
// Depends on lzss_pkg, lzss_if and the RTL of the decoder.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lzss_pkg::*;

  localparam int WINDOW_SIZE = 4096;
  localparam int COPY_BIAS   = 2;
  localparam int WIN_AW      = 12;
  localparam int MAX_DIST    = WINDOW_SIZE - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 110;
  localparam int LONG_GROUPS = 8;

  // Parser phases of the decoder
  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_ITEM = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] code_byte;
    logic              chunk_end;
  } code_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               is_status;
    logic [1:0]         end_status;
    logic [COUNT_W-1:0] produced_count;
    logic               run_last;
  } result_item_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  lzss_in_if  code_ch ();
  lzss_out_if result_ch ();

  lzss12_stream_decoder #(
    .WINDOW_DEPTH(WINDOW_SIZE),
    .LENGTH_BIAS (COPY_BIAS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .code       (code_ch),
    .result     (result_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus and scoreboard storage
  code_item_t   pending_codes[$];   // bytes waiting to be offered to the decoder
  code_item_t   chunk_buf[$];       // chunk under construction
  result_item_t expected_results[$];
  result_item_t step_results[$];    // results caused by the byte being decoded

  int err_count = 0;
  int cycle_count = 0;
  int gen_count;                    // generator's estimate of decoded bytes so far

  // Predicted decoder state
  logic [15:0]        pred_limit;
  logic [7:0]         pred_flags;
  logic [3:0]         pred_flags_left;
  logic [1:0]         pred_phase;
  logic [7:0]         pred_low;
  logic [COUNT_W-1:0] pred_count;
  logic [1:0]         pred_stop;
  logic [7:0]         pred_window [0:WINDOW_SIZE-1];

  // Handshake pacing
  int   in_gap = 0;
  int   out_stall = 0;
  bit   in_idle_on = 1'b1;
  bit   out_idle_on = 1'b1;
  bit   hold_off = 1'b0;
  event hold_go;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Write one decoded byte into the window and queue its result transaction.
  task automatic emit_decoded(input logic [7:0] b);
    result_item_t r;
    pred_window[pred_count[WIN_AW-1:0]] = b;
    pred_count = pred_count + 1'b1;
    r = '{out_byte: b, is_status: 1'b0, end_status: ST_RUNNING,
          produced_count: '0, run_last: 1'b0};
    step_results.push_back(r);
  endtask

  // Consume one control bit; drop back to flag parsing after the eighth.
  function automatic void advance_flag();
    pred_flags = pred_flags >> 1;
    if (pred_flags_left != 0)
      pred_flags_left = pred_flags_left - 1'b1;
    pred_phase = (pred_flags_left != 0) ? PH_ITEM : PH_FLAG;
  endfunction

  // Work out every result that one accepted code byte causes.
  task automatic decode_code_byte(input logic [7:0] b, input logic last);
    logic [15:0]       word;
    logic [4:0]        copy_len;
    logic [DIST_W-1:0] back_dist;
    logic [WIN_AW-1:0] src;
    result_item_t      r;
    step_results.delete();
    if (pred_stop == ST_RUNNING && pred_count >= pred_limit)
      pred_stop = ST_LIMIT;
    if (pred_stop == ST_RUNNING) begin
      case (pred_phase)
        PH_ITEM: begin
          if (pred_flags[0]) begin
            emit_decoded(b);
            advance_flag();
          end else begin
            pred_low = b;
            pred_phase = PH_HIGH;
          end
        end
        PH_HIGH: begin
          word = {b, pred_low};
          copy_len = {1'b0, word[15:12]} + 5'(COPY_BIAS);
          back_dist = word[DIST_W-1:0];
          if (back_dist == 0 || back_dist > pred_count) begin
            pred_stop = ST_BAD;
          end else begin
            // Copy byte by byte so that overlapping copies repeat fresh output
            for (int j = 0; j < copy_len && pred_count < pred_limit; j++) begin
              src = pred_count[WIN_AW-1:0] - back_dist;
              emit_decoded(pred_window[src]);
            end
            advance_flag();
          end
        end
        default: begin
          // Flag byte; the unused phase code lands here too
          pred_flags = b;
          pred_flags_left = 4'd8;
          pred_phase = PH_ITEM;
        end
      endcase
      if (pred_stop == ST_RUNNING && pred_count >= pred_limit)
        pred_stop = ST_LIMIT;
    end
    if (last) begin
      r = '{out_byte: '0, is_status: 1'b1,
            end_status: (pred_stop != ST_RUNNING) ? pred_stop : ST_EOF,
            produced_count: pred_count, run_last: 1'b0};
      step_results.push_back(r);
      // Start over for the next chunk; the window keeps its contents
      pred_flags = '0;
      pred_flags_left = '0;
      pred_phase = PH_FLAG;
      pred_low = '0;
      pred_count = '0;
      pred_stop = ST_RUNNING;
    end
    for (int i = 0; i < step_results.size(); i++) begin
      r = step_results[i];
      r.run_last = (i == step_results.size() - 1);
      expected_results.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offer the head of pending_codes at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      code_ch.valid <= 1'b0;
    end else if (in_gap != 0) begin
      in_gap = in_gap - 1;
      code_ch.valid <= 1'b0;
    end else if (pending_codes.size() != 0) begin
      code_ch.valid     <= 1'b1;
      code_ch.code_byte <= pending_codes[0].code_byte;
      code_ch.chunk_end <= pending_codes[0].chunk_end;
    end else begin
      code_ch.valid <= 1'b0;
    end
  end

  // Predict on each accepted code transaction, then draw the gap before the next one.
  always @(posedge clk) begin
    if (!rst && code_ch.valid && code_ch.ready) begin
      decode_code_byte(code_ch.code_byte, code_ch.chunk_end);
      void'(pending_codes.pop_front());
      if ($urandom_range(29) == 0)
        in_idle_on = !in_idle_on;
      in_gap = in_idle_on ? $urandom_range(13) : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready pacing, the long hold-off and the checker
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_off) begin
      result_ch.ready <= 1'b0;
    end else if (out_stall != 0) begin
      out_stall = out_stall - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Hold ready low long enough for the command queue to fill and stall the input.
  always begin
    @(hold_go);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // Compare each accepted result transaction with the oldest expectation.
  always @(posedge clk) begin
    result_item_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t ns: unexpected result, expected none, actual byte %0d status %0d",
                 $time, result_ch.out_byte, result_ch.is_status);
      end else begin
        want = expected_results.pop_front();
        check_field("out_byte",       want.out_byte,       result_ch.out_byte);
        check_field("is_status",      want.is_status,      result_ch.is_status);
        check_field("end_status",     want.end_status,     result_ch.end_status);
        check_field("produced_count", want.produced_count, result_ch.produced_count);
        check_field("run_last",       want.run_last,       result_ch.run_last);
      end
      if ($urandom_range(29) == 0)
        out_idle_on = !out_idle_on;
      out_stall = out_idle_on ? $urandom_range(13) : 0;
    end
  end

  // Bound the run in case the decoder hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_code(input logic [7:0] b);
    code_item_t c;
    c = '{code_byte: b, chunk_end: 1'b0};
    chunk_buf.push_back(c);
  endtask

  // Build one flag group: a flag byte and eight literals or back-references.
  // Distances stay inside what the chunk has produced unless allow_bad hits.
  task automatic add_group(input int lit_pct, input bit long_copies, input bit allow_bad);
    logic [7:0] flag;
    logic [7:0] body[$];
    int         back_dist;
    int         span;
    int         len_code;
    flag = '0;
    for (int i = 0; i < 8; i++) begin
      if (gen_count == 0 || $urandom_range(99) < lit_pct) begin
        flag[i] = 1'b1;
        body.push_back(8'($urandom_range(255)));
        gen_count++;
      end else begin
        len_code = long_copies ? 15 : $urandom_range(15);
        span = (gen_count > MAX_DIST) ? MAX_DIST : gen_count;
        case ($urandom_range(7))
          0:       back_dist = span;
          1:       back_dist = 1;
          default: back_dist = $urandom_range(span, 1);
        endcase
        if (allow_bad && $urandom_range(19) == 0) begin
          if (span == MAX_DIST || $urandom_range(1) == 0)
            back_dist = 0;
          else
            back_dist = $urandom_range(MAX_DIST, span + 1);
        end
        body.push_back(back_dist[7:0]);
        body.push_back({len_code[3:0], back_dist[11:8]});
        gen_count += len_code + COPY_BIAS;
      end
    end
    add_code(flag);
    foreach (body[k])
      add_code(body[k]);
  endtask

  // Move the chunk under construction to the pending queue; optionally cut its
  // tail (possibly mid back-reference) and mark its last byte as chunk end.
  task automatic close_chunk(input bit truncate, input bit with_end);
    code_item_t c;
    int         cut;
    if (truncate && chunk_buf.size() > 1) begin
      cut = $urandom_range(chunk_buf.size() - 1, 1);
      repeat (cut) void'(chunk_buf.pop_back());
    end
    if (with_end) begin
      c = chunk_buf[chunk_buf.size() - 1];
      c.chunk_end = 1'b1;
      chunk_buf[chunk_buf.size() - 1] = c;
    end
    foreach (chunk_buf[k])
      pending_codes.push_back(chunk_buf[k]);
    chunk_buf.delete();
    gen_count = 0;
  endtask

  // Write output_limit while the decoder is idle.
  task automatic set_output_limit(input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pred_limit = v;
  endtask

  // Wait until every byte is accepted and every result has arrived, then let a
  // trailing flag byte or back-reference settle inside the decoder.
  task automatic wait_for_quiet();
    while (pending_codes.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          random_total;
    int          phase_no;
    int          chunks;
    int          kind;
    bit          is_last;
    logic [15:0] limit_val;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    code_ch.valid = 1'b0;
    code_ch.code_byte = '0;
    code_ch.chunk_end = 1'b0;
    result_ch.ready = 1'b0;
    pred_limit = '0;
    pred_flags = '0;
    pred_flags_left = '0;
    pred_phase = PH_FLAG;
    pred_low = '0;
    pred_count = '0;
    pred_stop = ST_RUNNING;
    gen_count = 0;
    random_total = 0;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Limit still at its reset value of zero: the chunk stops before any output
    add_code(8'hFF);
    close_chunk(1'b0, 1'b1);
    wait_for_quiet();

    set_output_limit(16'hFFFF);
    // Two literals, an overlapping copy of the longest length, a short copy,
    // then a zero distance; the trailing byte is ignored after the stop
    add_code(8'h03);
    add_code(8'hFF);
    add_code(8'h00);
    add_code(8'h01);
    add_code(8'hF0);
    add_code(8'h02);
    add_code(8'h00);
    add_code(8'h00);
    add_code(8'h00);
    add_code(8'hAA);
    close_chunk(1'b0, 1'b1);
    // Distance reaching before the first output byte
    add_code(8'h00);
    add_code(8'h05);
    add_code(8'h80);
    close_chunk(1'b0, 1'b1);
    // Chunk ends with a back-reference missing its high byte
    add_code(8'h01);
    add_code(8'h5A);
    add_code(8'h01);
    close_chunk(1'b0, 1'b1);
    // Leave a chunk open so the next write lowers the limit under it
    add_code(8'h01);
    add_code(8'h33);
    add_code(8'h01);
    add_code(8'hF0);
    close_chunk(1'b0, 1'b0);
    wait_for_quiet();

    set_output_limit(16'd5);
    add_code(8'h99);
    close_chunk(1'b0, 1'b1);
    wait_for_quiet();

    // Copy cut short at the limit
    set_output_limit(16'd10);
    add_code(8'h01);
    add_code(8'h7E);
    add_code(8'h01);
    add_code(8'hF0);
    close_chunk(1'b0, 1'b1);
    wait_for_quiet();

    // One long chunk of mostly long copies reaching far back into the window
    set_output_limit(16'hFFFF);
    repeat (LONG_GROUPS) add_group(10, 1'b1, 1'b0);
    close_chunk(1'b0, 1'b1);
    wait_for_quiet();

    // Random phases, each under its own limit; mostly well-formed chunks with
    // junk, truncated chunks and bad distances mixed in
    phase_no = 0;
    while (random_total < RANDOM_ITEMS) begin
      case ($urandom_range(5))
        0:       limit_val = 16'd0;
        1:       limit_val = 16'd1;
        2:       limit_val = 16'($urandom_range(40, 2));
        3:       limit_val = 16'($urandom_range(400, 41));
        4:       limit_val = 16'hFFFF;
        default: limit_val = 16'($urandom_range(16'hFFFF));
      endcase
      if (phase_no == 0)
        limit_val = 16'hFFFF;
      set_output_limit(limit_val);
      chunks = (phase_no == 0) ? 2 : $urandom_range(4, 1);
      for (int c = 0; c < chunks; c++) begin
        kind = $urandom_range(9);
        is_last = (c == chunks - 1);
        if (kind == 0 && phase_no != 0) begin
          repeat ($urandom_range(6, 1)) add_code(8'($urandom_range(255)));
          close_chunk(1'b0, 1'b1);
        end else begin
          repeat ((phase_no == 0) ? 3 : $urandom_range(3, 1)) add_group(40, 1'b0, 1'b1);
          close_chunk(kind == 1, !is_last || $urandom_range(3) != 0);
        end
      end
      random_total += pending_codes.size();
      // Stall the receiver while the first random phase streams in
      if (phase_no == 0)
        -> hold_go;
      wait_for_quiet();
      phase_no++;
    end

    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
